>>> rtl/core/dilv_pkg.sv
package dilv_pkg;

    // Largest list that the value store holds by default.
    localparam int MAX_VALUES_DEFAULT = 512;

    // Largest magnitude that can still be a valid (negative) 32-bit value.
    localparam logic [31:0] LIMIT_MAG = 32'h8000_0000;

    // Character codes.
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    // Token status codes.
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_FORMAT = 3'd1;
    localparam logic [2:0] ST_RANGE  = 3'd2;
    localparam logic [2:0] ST_DUP    = 3'd3;
    localparam logic [2:0] ST_FULL   = 3'd4;

    // Token phases.
    localparam logic [1:0] PH_START  = 2'd0;
    localparam logic [1:0] PH_SIGNED = 2'd1;
    localparam logic [1:0] PH_DIGITS = 2'd2;

    // Scan request from the sequencer to the store.
    typedef struct packed {
        logic        start;
        logic [31:0] key;
    } scan_req_t;

    // Scan answer from the store to the sequencer.
    typedef struct packed {
        logic done;
        logic dup;
    } scan_rsp_t;

endpackage

>>> rtl/core/decimal_int_list_validator.sv
// Channel   Direction  tdata                          tuser                      tlast
// s_*       in         [7:0] ch                       [0] list_first [1] list_last token_last
// m_*       out        [31:0] token_value,            [0] list_failed            list_done
//                      [34:32] token_status, zero pad
//
// A character that does not end a token is taken while s_tready stays high for the next one.
// A character that ends a token drops s_tready while the duplicate search walks the value store
// one entry per cycle through its single read port; the read data is registered, then the
// sequencer decides in S_SCAN and loads the output register in S_OUT.
// Tokens rejected for format or range skip the search and go straight to S_OUT.
// Reset is asynchronous and active low; the value store itself is not cleared, as only
// entries below the fill count are ever read.
// A stalled output holds its result; characters are still accepted until the next token end,
// whose result then waits in the sequencer with s_tready low until the output is free.
module decimal_int_list_validator
    import dilv_pkg::*;
#(
    parameter int MAX_VALUES = MAX_VALUES_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic [1:0]  s_tuser,   // [0] list_first, [1] list_last
    input  logic        s_tlast,   // token_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] token_value, [34:32] token_status, [39:35] zero
    output logic [0:0]  m_tuser,   // [0] list_failed
    output logic        m_tlast    // list_done
);

    localparam int CW = $clog2(MAX_VALUES + 1);

    // Sequencer states.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          failed_reg, failed_next;

    // Token state built up character by character.
    logic [31:0]   acc_reg, acc_next;
    logic          over_reg, over_next;
    logic          neg_reg, neg_next;
    logic [1:0]    phase_reg, phase_next;
    logic          fbad_reg, fbad_next;

    // Result waiting for the output register.
    logic [31:0]   pend_value_reg, pend_value_next;
    logic [2:0]    pend_status_reg, pend_status_next;
    logic          pend_done_reg, pend_done_next;

    // Output register.
    logic          out_valid_reg, out_valid_next;
    logic [31:0]   out_value_reg, out_value_next;
    logic [2:0]    out_status_reg, out_status_next;
    logic          out_failed_reg, out_failed_next;
    logic          out_done_reg, out_done_next;

    // Values after the optional start of a new list.
    logic [31:0]   acc_base;
    logic          over_base, neg_base, fbad_base, failed_base;
    logic [1:0]    phase_base;
    logic [CW-1:0] count_base;

    // Token state once the current character has been taken in.
    logic [31:0]   tok_acc;
    logic          tok_over, tok_neg, tok_fbad;
    logic [1:0]    tok_phase;

    logic          accept;
    logic          is_digit, is_sign;
    logic [35:0]   prod;
    logic          fmt_err, range_err;
    logic [31:0]   signed_value;

    scan_req_t     scan_req;
    scan_rsp_t     scan_rsp;
    logic          wr_en;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_status_reg, out_value_reg};
    assign m_tuser  = out_failed_reg;
    assign m_tlast  = out_done_reg;

    assign is_digit = (s_tdata >= CH_ZERO) && (s_tdata <= CH_NINE);
    assign is_sign  = (s_tdata == CH_PLUS) || (s_tdata == CH_MINUS);

    // Ten times the magnitude plus the new digit, as two shifted copies and two adds.
    assign prod = {1'b0, acc_base, 3'b000} + {3'b000, acc_base, 1'b0}
                + {32'd0, s_tdata[3:0] - CH_ZERO[3:0]};

    // The first character of a new list restarts the list and the token state.
    always_comb
    begin
        if (s_tuser[0])
        begin
            acc_base    = '0;
            over_base   = 1'b0;
            neg_base    = 1'b0;
            phase_base  = PH_START;
            fbad_base   = 1'b0;
            failed_base = 1'b0;
            count_base  = '0;
        end
        else
        begin
            acc_base    = acc_reg;
            over_base   = over_reg;
            neg_base    = neg_reg;
            phase_base  = phase_reg;
            fbad_base   = fbad_reg;
            failed_base = failed_reg;
            count_base  = count_reg;
        end
    end

    // Character classification against the token grammar.
    always_comb
    begin
        tok_acc   = acc_base;
        tok_over  = over_base;
        tok_neg   = neg_base;
        tok_phase = phase_base;
        tok_fbad  = fbad_base;
        if (is_digit)
        begin
            tok_phase = PH_DIGITS;
            if (!over_base)
            begin
                if (prod > {4'd0, LIMIT_MAG})
                begin
                    tok_over = 1'b1;
                end
                else
                begin
                    tok_acc = prod[31:0];
                end
            end
        end
        else if (is_sign && (phase_base == PH_START))
        begin
            tok_neg   = (s_tdata == CH_MINUS);
            tok_phase = PH_SIGNED;
        end
        else
        begin
            tok_fbad = 1'b1;
        end
    end

    // Token decision on the updated token state.
    assign fmt_err      = tok_fbad || (tok_phase != PH_DIGITS);
    assign range_err    = tok_over || (!tok_neg && (tok_acc == LIMIT_MAG));
    assign signed_value = tok_neg ? (32'd0 - tok_acc) : tok_acc;

    assign scan_req.start = accept && s_tlast && !fmt_err && !range_err;
    assign scan_req.key   = signed_value;

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        failed_next      = failed_reg;
        acc_next         = acc_reg;
        over_next        = over_reg;
        neg_next         = neg_reg;
        phase_next       = phase_reg;
        fbad_next        = fbad_reg;
        pend_value_next  = pend_value_reg;
        pend_status_next = pend_status_reg;
        pend_done_next   = pend_done_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_value_next   = out_value_reg;
        out_status_next  = out_status_reg;
        out_failed_next  = out_failed_reg;
        out_done_next    = out_done_reg;
        wr_en            = 1'b0;

        if (accept)
        begin
            acc_next    = tok_acc;
            over_next   = tok_over;
            neg_next    = tok_neg;
            phase_next  = tok_phase;
            fbad_next   = tok_fbad;
            count_next  = count_base;
            failed_next = failed_base;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && s_tlast)
                begin
                    pend_done_next = s_tuser[1];
                    if (fmt_err || range_err)
                    begin
                        pend_status_next = fmt_err ? ST_FORMAT : ST_RANGE;
                        pend_value_next  = '0;
                        failed_next      = 1'b1;
                        state_next       = S_OUT;
                    end
                    else
                    begin
                        pend_value_next = signed_value;
                        state_next      = S_SCAN;
                    end
                    // The token is closed; the next character starts a fresh one.
                    acc_next   = '0;
                    over_next  = 1'b0;
                    neg_next   = 1'b0;
                    phase_next = PH_START;
                    fbad_next  = 1'b0;
                end
            end
            S_SCAN:
            begin
                if (scan_rsp.done)
                begin
                    if (scan_rsp.dup || (count_reg == CW'(MAX_VALUES)))
                    begin
                        pend_status_next = scan_rsp.dup ? ST_DUP : ST_FULL;
                        pend_value_next  = '0;
                        failed_next      = 1'b1;
                    end
                    else
                    begin
                        pend_status_next = ST_OK;
                        wr_en            = 1'b1;
                        count_next       = count_reg + CW'(1);
                    end
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = pend_value_reg;
                    out_status_next = pend_status_reg;
                    out_failed_next = failed_reg;
                    out_done_next   = pend_done_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            failed_reg    <= 1'b0;
            acc_reg       <= '0;
            over_reg      <= 1'b0;
            neg_reg       <= 1'b0;
            phase_reg     <= PH_START;
            fbad_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            failed_reg    <= failed_next;
            acc_reg       <= acc_next;
            over_reg      <= over_next;
            neg_reg       <= neg_next;
            phase_reg     <= phase_next;
            fbad_reg      <= fbad_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload carries no reset.
    always_ff @(posedge clk)
    begin
        pend_value_reg  <= pend_value_next;
        pend_status_reg <= pend_status_next;
        pend_done_reg   <= pend_done_next;
        out_value_reg   <= out_value_next;
        out_status_reg  <= out_status_next;
        out_failed_reg  <= out_failed_next;
        out_done_reg    <= out_done_next;
    end

    // The store holds the accepted values of the current list and runs the duplicate search.
    dilv_store #(
        .MAX_VALUES (MAX_VALUES)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (scan_req),
        .count   (count_reg),
        .wr_en   (wr_en),
        .wr_data (pend_value_reg),
        .rsp     (scan_rsp)
    );

endmodule

>>> rtl/core/dilv_store.sv
module dilv_store
    import dilv_pkg::*;
#(
    parameter int MAX_VALUES = MAX_VALUES_DEFAULT
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  scan_req_t                        req,
    input  logic [$clog2(MAX_VALUES+1)-1:0]  count,
    input  logic                             wr_en,
    input  logic [31:0]                      wr_data,
    output scan_rsp_t                        rsp
);

    localparam int AW = $clog2(MAX_VALUES);
    localparam int CW = $clog2(MAX_VALUES + 1);

    logic [31:0]   mem [MAX_VALUES];
    logic [31:0]   rd_data_reg;
    logic [31:0]   key_reg;
    logic [CW-1:0] idx_reg;
    logic          busy_reg;
    logic          rd_valid_reg;
    logic          hit_reg;
    logic          issue;
    logic          done;

    // One entry is read per cycle; the compare happens in the following cycle on the registered data.
    assign issue = busy_reg && (idx_reg < count);
    assign done  = busy_reg && !issue && !rd_valid_reg;

    assign rsp.done = done;
    assign rsp.dup  = hit_reg;

    // Writes land at the current fill count, which the sequencer keeps below the depth.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count[AW-1:0]] <= wr_data;
        end
        if (issue)
        begin
            rd_data_reg <= mem[idx_reg[AW-1:0]];
        end
        if (req.start)
        begin
            key_reg <= req.key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            idx_reg      <= '0;
            rd_valid_reg <= 1'b0;
            hit_reg      <= 1'b0;
        end
        else if (req.start)
        begin
            busy_reg     <= 1'b1;
            idx_reg      <= '0;
            rd_valid_reg <= 1'b0;
            hit_reg      <= 1'b0;
        end
        else if (busy_reg)
        begin
            if (issue)
            begin
                idx_reg <= idx_reg + CW'(1);
            end
            rd_valid_reg <= issue;
            if (rd_valid_reg && (rd_data_reg == key_reg))
            begin
                hit_reg <= 1'b1;
            end
            if (done)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

endmodule

>>> rtl/core/dilv_checker.sv
module dilv_checker
    import dilv_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // A waiting result is not withdrawn.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn while stalled");

    // A rejected token reports a zero value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[34:32] != ST_OK) |-> (m_tdata[31:0] == 32'd0))
        else $error("rejected token carries a value");

    // A rejected token always marks its list as failed.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[34:32] != ST_OK) |-> m_tuser[0])
        else $error("rejection without list failure");

    // Status stays within the defined codes and the pad bits stay clear.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[34:32] <= ST_FULL) && (m_tdata[39:35] == 5'd0))
        else $error("bad status or pad bits");

    // Taking the end of a token always stalls the input in the cycle after.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("token end taken without a decision cycle");

endmodule

bind decimal_int_list_validator dilv_checker u_dilv_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
